FILE: sv/mdq_pkg.sv
// ----------------------------------------------------------------------------
// Multi-deque buffer manager package
// Shared constants, opcode and status codes, and the controller command struct.
// ----------------------------------------------------------------------------
package mdq_pkg;

	localparam int NumDeques = 256;
	localparam int PoolNodes = 1024;
	localparam int ValueBits = 32;

	localparam int OpBits = 2;
	localparam int IndexBits = 8;
	localparam int IoValueBits = 32;
	localparam int StatusBits = 2;

	localparam logic [OpBits-1:0] OP_PUSH_BACK = 2'd0;
	localparam logic [OpBits-1:0] OP_PUSH_FRONT = 2'd1;
	localparam logic [OpBits-1:0] OP_POP_FRONT = 2'd2;
	localparam logic [OpBits-1:0] OP_POP_BACK = 2'd3;

	localparam logic [StatusBits-1:0] ST_PUSHED = 2'd0;
	localparam logic [StatusBits-1:0] ST_POPPED = 2'd1;
	localparam logic [StatusBits-1:0] ST_EMPTY = 2'd2;
	localparam logic [StatusBits-1:0] ST_FULL = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;   // latch the request and read the deque tables
		logic read_node; // read the node store at the link addresses
		logic commit;    // write back pointers, links and counters
	} cmd_t;

endpackage

FILE: sv/mdq_ctrl.sv
// ----------------------------------------------------------------------------
// Multi-deque controller
// Sequences one request through table read, node read and write-back.
// ----------------------------------------------------------------------------
module mdq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output mdq_pkg::cmd_t  cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_NODE = 2'd1;
	localparam logic [1:0] S_COMMIT = 2'd2;

	logic [1:0] state_q;
	logic       out_valid_q;

	// A new request may enter while the previous result waits, as long as
	// that result is taken by the time this one commits.
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.capture = in_valid && in_ready;
		cmd.read_node = (state_q == S_NODE);
		cmd.commit = (state_q == S_COMMIT) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_NODE;
				S_NODE: state_q <= S_COMMIT;
				S_COMMIT: if (cmd.commit) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: sv/mdq_datapath.sv
// ----------------------------------------------------------------------------
// Multi-deque datapath
// Deque pointer tables, node store, free list and result registers.
// ----------------------------------------------------------------------------
module mdq_datapath #(
	parameter int NUM_DEQUES = mdq_pkg::NumDeques,
	parameter int POOL_NODES = mdq_pkg::PoolNodes,
	parameter int VALUE_BITS = mdq_pkg::ValueBits
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  mdq_pkg::cmd_t                           cmd,
	input  logic [mdq_pkg::OpBits-1:0]              opcode,
	input  logic [mdq_pkg::IndexBits-1:0]           deque_index,
	input  logic signed [mdq_pkg::IoValueBits-1:0]  push_value,
	output logic [mdq_pkg::StatusBits-1:0]          status,
	output logic signed [mdq_pkg::IoValueBits-1:0]  pop_value
);

	localparam int DqBits = (NUM_DEQUES > 1) ? $clog2(NUM_DEQUES) : 1;
	localparam int NdBits = $clog2(POOL_NODES);
	localparam int CntBits = NdBits + 1;
	localparam int IoBits = mdq_pkg::IoValueBits;

	logic [NdBits-1:0]     head_mem [NUM_DEQUES];
	logic [NdBits-1:0]     tail_mem [NUM_DEQUES];
	logic [NUM_DEQUES-1:0] occ_q;
	logic [VALUE_BITS-1:0] val_mem [POOL_NODES];
	logic [NdBits-1:0]     next_mem [POOL_NODES];
	logic [NdBits-1:0]     prev_mem [POOL_NODES];

	logic [CntBits-1:0]    fresh_q;
	logic [NdBits-1:0]     free_head_q;
	logic [CntBits-1:0]    free_len_q;

	logic [mdq_pkg::OpBits-1:0] op_q;
	logic [DqBits-1:0]     dq_q;
	logic [VALUE_BITS-1:0] pval_q;
	logic                  occ_s1;
	logic [NdBits-1:0]     head_s1, tail_s1;
	logic [NdBits-1:0]     pop_next_s2, pop_prev_s2, free_next_s2;
	logic [VALUE_BITS-1:0] pop_val_s2;
	logic [mdq_pkg::StatusBits-1:0] status_q;
	logic [IoBits-1:0]     pop_value_q;

	logic [DqBits-1:0] wrap_tbl [2**mdq_pkg::IndexBits];
	logic [DqBits-1:0] dq_in;
	logic              is_push, have_free, have_fresh, single;
	logic [NdBits-1:0] pop_node, new_node;
	logic [mdq_pkg::StatusBits-1:0] st;

	// The request index wraps onto the deque count through a constant table.
	for (genvar g = 0; g < 2**mdq_pkg::IndexBits; g++) begin : g_wrap
		assign wrap_tbl[g] = DqBits'(g % NUM_DEQUES);
	end

	assign dq_in = wrap_tbl[deque_index];

	assign is_push = (op_q == mdq_pkg::OP_PUSH_BACK) || (op_q == mdq_pkg::OP_PUSH_FRONT);
	assign have_free = (free_len_q != '0);
	assign have_fresh = (fresh_q < CntBits'(POOL_NODES));
	assign single = (head_s1 == tail_s1);
	assign pop_node = (op_q == mdq_pkg::OP_POP_FRONT) ? head_s1 : tail_s1;
	assign new_node = have_free ? free_head_q : fresh_q[NdBits-1:0];

	always_comb begin
		if (is_push) begin
			st = (have_free || have_fresh) ? mdq_pkg::ST_PUSHED : mdq_pkg::ST_FULL;
		end else begin
			st = occ_s1 ? mdq_pkg::ST_POPPED : mdq_pkg::ST_EMPTY;
		end
	end

	// Stage 1: latch the request and read the deque tables.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= opcode;
			dq_q <= dq_in;
			pval_q <= VALUE_BITS'(unsigned'(push_value));
			head_s1 <= head_mem[dq_in];
			tail_s1 <= tail_mem[dq_in];
			occ_s1 <= occ_q[dq_in];
		end
	end

	// Stage 2: read the node store for the popped node and the free list head.
	always_ff @(posedge clk) begin
		if (cmd.read_node) begin
			pop_next_s2 <= next_mem[pop_node];
			pop_prev_s2 <= prev_mem[pop_node];
			pop_val_s2 <= val_mem[pop_node];
			free_next_s2 <= next_mem[free_head_q];
		end
	end

	// Node store writes. At most one next and one prev write per request.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (is_push && st == mdq_pkg::ST_PUSHED) begin
				val_mem[new_node] <= pval_q;
				if (occ_s1) begin
					if (op_q == mdq_pkg::OP_PUSH_BACK) begin
						prev_mem[new_node] <= tail_s1;
						next_mem[tail_s1] <= new_node;
					end else begin
						next_mem[new_node] <= head_s1;
						prev_mem[head_s1] <= new_node;
					end
				end
			end else if (st == mdq_pkg::ST_POPPED) begin
				next_mem[pop_node] <= free_head_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (is_push && st == mdq_pkg::ST_PUSHED) begin
				if (!occ_s1 || op_q == mdq_pkg::OP_PUSH_FRONT) head_mem[dq_q] <= new_node;
				if (!occ_s1 || op_q == mdq_pkg::OP_PUSH_BACK) tail_mem[dq_q] <= new_node;
			end else if (st == mdq_pkg::ST_POPPED && !single) begin
				if (op_q == mdq_pkg::OP_POP_FRONT) head_mem[dq_q] <= pop_next_s2;
				else tail_mem[dq_q] <= pop_prev_s2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			fresh_q <= '0;
			free_head_q <= '0;
			free_len_q <= '0;
		end else if (cmd.commit) begin
			if (is_push && st == mdq_pkg::ST_PUSHED) begin
				occ_q[dq_q] <= 1'b1;
				if (have_free) begin
					free_head_q <= free_next_s2;
					free_len_q <= free_len_q - 1'b1;
				end else begin
					fresh_q <= fresh_q + 1'b1;
				end
			end else if (st == mdq_pkg::ST_POPPED) begin
				if (single) occ_q[dq_q] <= 1'b0;
				free_head_q <= pop_node;
				free_len_q <= free_len_q + 1'b1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= st;
			if (st == mdq_pkg::ST_POPPED) begin
				pop_value_q <= IoBits'(pop_val_s2);
			end else begin
				pop_value_q <= '0;
			end
		end
	end

	assign status = status_q;
	assign pop_value = signed'(pop_value_q);

endmodule

FILE: sv/multi_deque_buffer_manager_top.sv
// ----------------------------------------------------------------------------
// Multi-deque buffer manager
// Many deques share one node pool through doubly linked lists and a free list.
//
//   channel  direction  signals
//   in       input      in_valid, in_ready, opcode, deque_index, push_value
//   out      output     out_valid, out_ready, status, pop_value
//
// Each request passes through deque table read, node store read, and
// write-back in sequence, set by the synchronous memory reads.
// Reset clears the occupied bits and the pool counters; no clearing pass.
// A result waiting on out_ready holds the write-back of the next request.
// ----------------------------------------------------------------------------
module multi_deque_buffer_manager_top #(
	parameter int NUM_DEQUES = mdq_pkg::NumDeques,
	parameter int POOL_NODES = mdq_pkg::PoolNodes,
	parameter int VALUE_BITS = mdq_pkg::ValueBits
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [mdq_pkg::OpBits-1:0]              opcode,
	input  logic [mdq_pkg::IndexBits-1:0]           deque_index,
	input  logic signed [mdq_pkg::IoValueBits-1:0]  push_value,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [mdq_pkg::StatusBits-1:0]          status,
	output logic signed [mdq_pkg::IoValueBits-1:0]  pop_value
);

	mdq_pkg::cmd_t  cmd;

	mdq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd)
	);

	mdq_datapath #(
		.NUM_DEQUES(NUM_DEQUES), .POOL_NODES(POOL_NODES), .VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .opcode(opcode),
		.deque_index(deque_index), .push_value(push_value),
		.status(status), .pop_value(pop_value)
	);

	// A transfer in is followed by a node read in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.capture |=> cmd.read_node)
		else $error("node read did not follow capture");
	// A commit always produces a valid result in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.commit |=> out_valid)
		else $error("commit without result");
	// Non-pop results carry a zero value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != mdq_pkg::ST_POPPED |-> pop_value == '0)
		else $error("nonzero value on a non-pop result");
	// The controller sequence issues at most one command at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.read_node, cmd.commit}))
		else $error("overlapping commands");

endmodule

FILE: bench/tb_multi_deque_buffer_manager_top.sv
// ----------------------------------------------------------------------------
// Multi-deque buffer manager testbench
// Drives push and pop requests over the input channel, predicts each status
// and popped value with a behavioral model of the shared node pool, and
// compares every transfer on the output channel against it.
// ----------------------------------------------------------------------------
module tb_multi_deque_buffer_manager_top;

	localparam int WatchdogLimit = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [mdq_pkg::OpBits-1:0] opcode = mdq_pkg::OP_PUSH_BACK;
	logic [mdq_pkg::IndexBits-1:0] deque_index = '0;
	logic signed [mdq_pkg::IoValueBits-1:0] push_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [mdq_pkg::StatusBits-1:0] status;
	logic signed [mdq_pkg::IoValueBits-1:0] pop_value;

	typedef struct packed {
		logic [mdq_pkg::StatusBits-1:0] status;
		logic [mdq_pkg::IoValueBits-1:0] value;
	} reply_t;

	// Model state: each deque is a queue of values; pool accounting by count.
	logic [mdq_pkg::IoValueBits-1:0] deque_contents[mdq_pkg::NumDeques][$];
	int nodes_in_use = 0;
	reply_t reply_queue[$];
	int failures = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int stall_mode = 0;

	multi_deque_buffer_manager_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .deque_index(deque_index), .push_value(push_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .pop_value(pop_value)
	);

	always #5 clk = ~clk;

	function automatic reply_t predict_request(logic [mdq_pkg::OpBits-1:0] op,
			logic [mdq_pkg::IndexBits-1:0] idx, logic [mdq_pkg::IoValueBits-1:0] val);
		reply_t r;
		int dq;
		r = '0;
		dq = idx % mdq_pkg::NumDeques;
		if (op == mdq_pkg::OP_PUSH_BACK || op == mdq_pkg::OP_PUSH_FRONT) begin
			if (nodes_in_use >= mdq_pkg::PoolNodes) begin
				r.status = mdq_pkg::ST_FULL;
			end else begin
				nodes_in_use++;
				if (op == mdq_pkg::OP_PUSH_BACK)
					deque_contents[dq].insert(deque_contents[dq].size(), val);
				else
					deque_contents[dq].insert(0, val);
				r.status = mdq_pkg::ST_PUSHED;
			end
		end else if (deque_contents[dq].size() == 0) begin
			r.status = mdq_pkg::ST_EMPTY;
		end else begin
			r.status = mdq_pkg::ST_POPPED;
			nodes_in_use--;
			if (op == mdq_pkg::OP_POP_FRONT) begin
				r.value = deque_contents[dq][0];
				deque_contents[dq].delete(0);
			end else begin
				r.value = deque_contents[dq][$];
				deque_contents[dq].delete(deque_contents[dq].size() - 1);
			end
		end
		return r;
	endfunction

	// Sends one request in a burst/gap pattern; the prediction is made at transfer.
	// Valid stays high between requests of a burst and drops only for a gap.
	task automatic send_request(logic [mdq_pkg::OpBits-1:0] op,
			logic [mdq_pkg::IndexBits-1:0] idx, logic [mdq_pkg::IoValueBits-1:0] val);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		in_valid <= 1'b1;
		opcode <= op;
		deque_index <= idx;
		push_value <= val;
		do @(posedge clk); while (!in_ready);
		reply_queue.insert(reply_queue.size(), predict_request(op, idx, val));
	endtask

	// Receiver stall pattern, changed now and then.
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= ($urandom_range(0, 1) != 0);
			default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		reply_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (reply_queue.size() == 0) begin
				$error("unexpected result transfer: status %0d", status);
				failures++;
			end else begin
				exp_r = reply_queue[0];
				reply_queue.delete(0);
				if (status !== exp_r.status) begin
					$error("status: expected %0d, actual %0d", exp_r.status, status);
					failures++;
				end
				if (pop_value !== exp_r.value) begin
					$error("pop_value: expected %0d, actual %0d",
						$signed(exp_r.value), pop_value);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("FAIL multi_deque_buffer_manager_top");
			$finish;
		end
	end

	task automatic test_directed();
		send_request(mdq_pkg::OP_POP_FRONT, 8'd0, 32'd0);
		send_request(mdq_pkg::OP_POP_BACK, 8'd255, 32'hFFFF_FFFF);
		send_request(mdq_pkg::OP_PUSH_BACK, 8'd0, 32'h7FFF_FFFF);
		send_request(mdq_pkg::OP_PUSH_BACK, 8'd0, 32'h8000_0000);
		send_request(mdq_pkg::OP_PUSH_FRONT, 8'd0, 32'hFFFF_FFFF);
		send_request(mdq_pkg::OP_PUSH_FRONT, 8'd255, 32'h0000_0000);
		send_request(mdq_pkg::OP_POP_BACK, 8'd0, 32'd0);
		send_request(mdq_pkg::OP_POP_FRONT, 8'd0, 32'd0);
		send_request(mdq_pkg::OP_POP_FRONT, 8'd0, 32'd0);
		send_request(mdq_pkg::OP_POP_BACK, 8'd0, 32'd0);
		send_request(mdq_pkg::OP_POP_BACK, 8'd255, 32'd0);
		send_request(mdq_pkg::OP_PUSH_FRONT, 8'd17, 32'h1234_5678);
		send_request(mdq_pkg::OP_PUSH_BACK, 8'd17, 32'hA5A5_5A5A);
		send_request(mdq_pkg::OP_POP_FRONT, 8'd17, 32'd0);
		send_request(mdq_pkg::OP_POP_FRONT, 8'd17, 32'd0);
	endtask

	// Random requests over the first deque_span deques; few deques make lists grow long and ends meet often.
	task automatic test_random_mix(int count, int deque_span, int push_weight);
		logic [mdq_pkg::OpBits-1:0] op;
		for (int i = 0; i < count; i++) begin
			op = ($urandom_range(0, 99) < push_weight)
				? mdq_pkg::OpBits'($urandom_range(0, 1))
				: mdq_pkg::OpBits'($urandom_range(2, 3));
			send_request(op, mdq_pkg::IndexBits'($urandom_range(0, deque_span - 1)),
				$urandom);
		end
	endtask

	// Fills the pool so that pushes are dropped, then drains part of it.
	task automatic test_pool_full();
		while (nodes_in_use < mdq_pkg::PoolNodes)
			send_request(mdq_pkg::OpBits'($urandom_range(0, 1)),
				mdq_pkg::IndexBits'($urandom), $urandom);
		for (int i = 0; i < 6; i++)
			send_request(mdq_pkg::OpBits'($urandom_range(0, 1)),
				mdq_pkg::IndexBits'($urandom), $urandom);
		test_random_mix(300, 256, 20);
		test_random_mix(60, 256, 80);
	endtask

	initial begin
		int waited;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_mix(250, 4, 55);
		test_pool_full();
		test_random_mix(150, 256, 45);
		in_valid <= 1'b0;
		waited = 0;
		while (reply_queue.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (failures == 0 && reply_queue.size() == 0) begin
			$display("PASS multi_deque_buffer_manager_top");
		end else begin
			$display("FAIL multi_deque_buffer_manager_top");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/mdq_pkg.sv
sv/mdq_ctrl.sv
sv/mdq_datapath.sv
sv/multi_deque_buffer_manager_top.sv
bench/tb_multi_deque_buffer_manager_top.sv
